// File: src/sst_pkg.sv
package sst_pkg;

  // control register bit positions
  localparam int unsigned CTRL_ENABLE_BIT = 0;
  localparam int unsigned CTRL_IRQ_BIT    = 1;
  localparam int unsigned CTRL_CLKSRC_BIT = 2;
  localparam int unsigned CTRL_FLAG_BIT   = 16;

  localparam int unsigned FIELD_WIDTH = 24;

  // input operation codes
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // register select codes
  typedef enum logic [1:0] {
    SEL_CTRL    = 2'd0,
    SEL_RELOAD  = 2'd1,
    SEL_CURRENT = 2'd2,
    SEL_NONE    = 2'd3
  } sel_t;

  // decoded command kinds
  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_TICK,
    CMD_RD_CTRL,
    CMD_RD_RELOAD,
    CMD_RD_CURRENT,
    CMD_WR_CTRL,
    CMD_WR_RELOAD,
    CMD_WR_CURRENT
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0]             operation;
    logic [1:0]             reg_select;
    logic [FIELD_WIDTH-1:0] write_data;
  } in_word_t;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] read_data;
    logic [FIELD_WIDTH-1:0] elapsed_ticks;
    logic                   irq;
    logic                   count_flag;
  } out_word_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [FIELD_WIDTH-1:0] data;
  } cmd_t;

endpackage

// File: src/sst_front.sv
module sst_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  sst_pkg::in_word_t in_word,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output sst_pkg::cmd_t    cmd
);

  logic          valid_r, valid_nxt;
  sst_pkg::cmd_t cmd_r, cmd_nxt;
  sst_pkg::cmd_t decoded;

  // classify the incoming word
  always_comb begin
    decoded.data = in_word.write_data;
    decoded.kind = sst_pkg::CMD_NOP;
    case (sst_pkg::op_t'(in_word.operation))
      sst_pkg::OP_TICK: decoded.kind = sst_pkg::CMD_TICK;
      sst_pkg::OP_READ: begin
        case (sst_pkg::sel_t'(in_word.reg_select))
          sst_pkg::SEL_CTRL:    decoded.kind = sst_pkg::CMD_RD_CTRL;
          sst_pkg::SEL_RELOAD:  decoded.kind = sst_pkg::CMD_RD_RELOAD;
          sst_pkg::SEL_CURRENT: decoded.kind = sst_pkg::CMD_RD_CURRENT;
          default:              decoded.kind = sst_pkg::CMD_NOP;
        endcase
      end
      sst_pkg::OP_WRITE: begin
        case (sst_pkg::sel_t'(in_word.reg_select))
          sst_pkg::SEL_CTRL:    decoded.kind = sst_pkg::CMD_WR_CTRL;
          sst_pkg::SEL_RELOAD:  decoded.kind = sst_pkg::CMD_WR_RELOAD;
          sst_pkg::SEL_CURRENT: decoded.kind = sst_pkg::CMD_WR_CURRENT;
          default:              decoded.kind = sst_pkg::CMD_NOP;
        endcase
      end
      default: decoded.kind = sst_pkg::CMD_NOP;
    endcase
  end

  // one-word holding stage ahead of the queue
  assign in_ready = !valid_r || cmd_ready;

  always_comb begin
    valid_nxt = valid_r;
    cmd_nxt   = cmd_r;
    if (in_ready) begin
      valid_nxt = in_valid;
      if (in_valid) begin
        cmd_nxt = decoded;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

endmodule

// File: src/sst_queue.sv
module sst_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  sst_pkg::cmd_t push_cmd,
  input  logic          push_valid,
  output logic          push_ready,
  output sst_pkg::cmd_t pop_cmd,
  output logic          pop_valid,
  input  logic          pop_ready
);

  sst_pkg::cmd_t entry_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;
  logic          push, pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_cmd    = entry_r[rd_ptr_r];

  assign push = push_valid && push_ready;
  assign pop  = pop_valid && pop_ready;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: src/sst_back.sv
module sst_back #(
  parameter int unsigned COUNTER_WIDTH   = 24,
  parameter int unsigned PRESCALE_DIVIDE = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  sst_pkg::cmd_t      cmd,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output sst_pkg::out_word_t out_word
);

  localparam int unsigned FW = sst_pkg::FIELD_WIDTH;
  localparam int unsigned CW = COUNTER_WIDTH;
  localparam int unsigned PW = $clog2(PRESCALE_DIVIDE);
  localparam logic [PW-1:0] PSC_LAST = PW'(PRESCALE_DIVIDE - 1);

  logic          one_shot_r;
  logic          enable_r, enable_nxt;
  logic          irq_en_r, irq_en_nxt;
  logic          clksrc_r, clksrc_nxt;
  logic          flag_r, flag_nxt;
  logic [CW-1:0] reload_r, reload_nxt;
  logic [CW-1:0] current_r, current_nxt;
  logic [PW-1:0] psc_r, psc_nxt;

  logic               out_valid_r, out_valid_nxt;
  sst_pkg::out_word_t out_word_r, out_word_nxt;

  logic          take;
  logic          do_step;
  logic          irq;
  logic [CW-1:0] dec_value;
  logic [CW-1:0] elapsed;
  logic [FW-1:0] rdata;
  logic [CW+FW-1:0] data_ext;
  logic [CW+FW-1:0] reload_ext;
  logic [CW+FW-1:0] current_ext;
  logic [CW+FW-1:0] elapsed_ext;

  assign take      = cmd_valid && (!out_valid_r || out_ready);
  assign cmd_ready = !out_valid_r || out_ready;
  assign dec_value = current_r - CW'(1);

  // width adaptation between counter and 24-bit fields
  assign data_ext    = {{CW{1'b0}}, cmd.data};
  assign reload_ext  = {{FW{1'b0}}, reload_r};
  assign current_ext = {{FW{1'b0}}, current_r};
  assign elapsed_ext = {{FW{1'b0}}, elapsed};

  // command execution
  always_comb begin
    enable_nxt  = enable_r;
    irq_en_nxt  = irq_en_r;
    clksrc_nxt  = clksrc_r;
    flag_nxt    = flag_r;
    reload_nxt  = reload_r;
    current_nxt = current_r;
    psc_nxt     = psc_r;
    do_step     = 1'b0;
    irq         = 1'b0;
    rdata       = '0;

    case (cmd.kind)
      sst_pkg::CMD_TICK: begin
        if (enable_r) begin
          if (clksrc_r) begin
            do_step = 1'b1;
          end else if (psc_r == PSC_LAST) begin
            psc_nxt = '0;
            do_step = 1'b1;
          end else begin
            psc_nxt = psc_r + PW'(1);
          end
        end
      end
      sst_pkg::CMD_RD_CTRL: begin
        rdata[sst_pkg::CTRL_ENABLE_BIT] = enable_r;
        rdata[sst_pkg::CTRL_IRQ_BIT]    = irq_en_r;
        rdata[sst_pkg::CTRL_CLKSRC_BIT] = clksrc_r;
        rdata[sst_pkg::CTRL_FLAG_BIT]   = flag_r;
        flag_nxt = 1'b0;
      end
      sst_pkg::CMD_RD_RELOAD:  rdata = reload_ext[FW-1:0];
      sst_pkg::CMD_RD_CURRENT: rdata = current_ext[FW-1:0];
      sst_pkg::CMD_WR_CTRL: begin
        enable_nxt = cmd.data[sst_pkg::CTRL_ENABLE_BIT];
        irq_en_nxt = cmd.data[sst_pkg::CTRL_IRQ_BIT];
        clksrc_nxt = cmd.data[sst_pkg::CTRL_CLKSRC_BIT];
      end
      sst_pkg::CMD_WR_RELOAD: reload_nxt = data_ext[CW-1:0];
      sst_pkg::CMD_WR_CURRENT: begin
        current_nxt = '0;
        flag_nxt    = 1'b0;
      end
      default: ;
    endcase

    // one counting step: reload on zero, flag on reaching zero
    if (do_step) begin
      if (current_r == '0) begin
        current_nxt = reload_r;
      end else begin
        current_nxt = dec_value;
        if (dec_value == '0) begin
          flag_nxt = 1'b1;
          irq      = irq_en_r;
          if (one_shot_r) begin
            enable_nxt  = 1'b0;
            irq_en_nxt  = 1'b0;
            reload_nxt  = '0;
            current_nxt = '0;
          end
        end
      end
    end
  end

  assign elapsed = reload_nxt - current_nxt;

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (take) begin
      out_valid_nxt              = 1'b1;
      out_word_nxt.read_data     = rdata;
      out_word_nxt.elapsed_ticks = elapsed_ext[FW-1:0];
      out_word_nxt.irq           = irq;
      out_word_nxt.count_flag    = flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_shot_r  <= 1'b0;
      enable_r    <= 1'b0;
      irq_en_r    <= 1'b0;
      clksrc_r    <= 1'b0;
      flag_r      <= 1'b0;
      reload_r    <= '0;
      current_r   <= '0;
      psc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        one_shot_r <= cfg_wdata;
      end
      if (take) begin
        enable_r  <= enable_nxt;
        irq_en_r  <= irq_en_nxt;
        clksrc_r  <= clksrc_nxt;
        flag_r    <= flag_nxt;
        reload_r  <= reload_nxt;
        current_r <= current_nxt;
        psc_r     <= psc_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// File: src/system_tick_timer.sv
// system tick timer
//
// in channel (in_valid / in_ready / in_word) carries one word per item: a clock
// tick, a register read or a register write to control, reload or current value.
// out channel (out_valid / out_ready / out_word) returns exactly one result word
// per input word, in order: read data, elapsed ticks, irq pulse and count flag.
// cfg_we / cfg_wdata sets the one-shot mode bit; write it only while idle.
//
// an accepted input word passes a decode register, a two-entry command queue and
// the execute stage with its output register before it appears at the output.
// throughput is one word per cycle while the receiver takes output, set by the
// execute stage that updates counter, prescaler and flags together.
//
// when the receiver stalls, the output register holds its word, the queue fills,
// and in_ready drops once decode register and queue are full (4 words buffered, counting the output register).
// synchronous reset clears all timer state, mode bit and the pipeline; there is
// no clearing pass, in_ready is high the cycle after reset.
module system_tick_timer #(
  parameter int unsigned COUNTER_WIDTH   = 24,
  parameter int unsigned PRESCALE_DIVIDE = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sst_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output sst_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);

  sst_pkg::cmd_t front_cmd;
  sst_pkg::cmd_t back_cmd;
  logic          front_valid;
  logic          front_ready;
  logic          back_valid;
  logic          back_ready;

  // decode stage
  sst_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  // command queue
  sst_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cmd   (front_cmd),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_cmd    (back_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  // execute stage
  sst_back #(
    .COUNTER_WIDTH   (COUNTER_WIDTH),
    .PRESCALE_DIVIDE (PRESCALE_DIVIDE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (back_cmd),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  // checks
  a_irq_has_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.irq |-> out_word.count_flag)
    else $error("irq reported without count flag");

  a_front_holds: assert property (@(posedge clk) disable iff (!rst_n)
    front_valid && !front_ready |=> front_valid && $stable(front_cmd))
    else $error("decode stage dropped a stalled command");

  a_back_holds: assert property (@(posedge clk) disable iff (!rst_n)
    back_valid && !back_ready |=> back_valid && $stable(back_cmd))
    else $error("queue head changed while execute stage stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !front_valid && !back_valid)
    else $error("pipeline not empty after reset");

endmodule
